// ===== rtl/core/scaled_sprite_blitter_2bpp_macros.svh =====
// Assertion shorthands for the sprite blitter. Both expect signals named clk and arst_n
// in the scope where they are used.
`ifndef SCALED_SPRITE_BLITTER_2BPP_MACROS_SVH
`define SCALED_SPRITE_BLITTER_2BPP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sprite blitter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sprite blitter: next-cycle check failed");

`endif

// ===== rtl/core/ssb_pkg.sv =====
`default_nettype none
package ssb_pkg;

	localparam int DEF_SCREEN_WIDTH = 240;
	localparam int DEF_BAND_HEIGHT  = 16;
	localparam int DEF_STAGE_TOP    = 24;
	localparam int DEF_MAX_ART_SIDE = 32;

	// Signed screen coordinate width; covers center, sprite extent and right edge.
	localparam int CW     = 12;
	// Clamped sprite side, 1..MAX_ART_SIDE (at most 63).
	localparam int SIDE_W = 7;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] SHADE_CLEAR = 2'd3;

	localparam int STAGE_BOTTOM = 236;
	localparam int LOW_ROW      = 160;
	localparam int LOW_RIGHT    = 104;

	// HUD rectangles, half-open on the high side.
	localparam int HUD_A_X2 = 120;
	localparam int HUD_A_Y2 = 116;
	localparam int HUD_B_X1 = 8;
	localparam int HUD_B_X2 = 232;
	localparam int HUD_B_Y1 = 8;
	localparam int HUD_B_Y2 = 24;
	localparam int HUD_C_X1 = 8;
	localparam int HUD_C_X2 = 120;
	localparam int HUD_C_Y1 = 30;
	localparam int HUD_C_Y2 = 46;
	localparam int HUD_D_X1 = 8;
	localparam int HUD_D_X2 = 88;
	localparam int HUD_D_Y1 = 50;
	localparam int HUD_D_Y2 = 66;
	localparam int HUD_E_X1 = 96;
	localparam int HUD_E_X2 = 110;
	localparam int HUD_E_Y1 = 68;
	localparam int HUD_E_Y2 = 75;

	typedef enum logic [2:0] {
		REG_BAND_Y,
		REG_ART_WIDTH,
		REG_ART_HEIGHT,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_SCALE,
		REG_FLIP_BITS,
		REG_PALETTE
	} ssb_reg_t;

	typedef struct packed {
		logic [7:0]  band_y;
		logic [5:0]  art_width;
		logic [5:0]  art_height;
		logic [9:0]  center_x;
		logic [9:0]  center_y;
		logic [1:0]  scale;
		logic [1:0]  flip_bits;
		logic [47:0] palette_words;
	} ssb_cfg_t;

	// One classified byte: shades, which of its four pixels are drawn, the screen row
	// of the first replica row and the screen column of the first pixel's first replica.
	typedef struct packed {
		logic [7:0]           shades;
		logic [3:0]           mask;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] pxb;
	} ssb_item_t;

	typedef struct packed {
		logic busy;
		logic flush;
		logic hold;
	} ssb_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssb_in_if.sv =====
`default_nettype none
interface ssb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] art_byte;

	modport source (output valid, output art_byte, input ready);
	modport sink (input valid, input art_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ssb_out_if.sv =====
`default_nettype none
interface ssb_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pixel_x;
	logic [3:0]  pixel_row;
	logic [15:0] color;
	logic        last;

	modport source (output valid, output pixel_x, output pixel_row, output color,
		output last, input ready);
	modport sink (input valid, input pixel_x, input pixel_row, input color,
		input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/scaled_sprite_blitter_2bpp.sv =====
`default_nettype none
// Scaled 2-bit-per-pixel sprite blitter. Sprite bytes arrive in storage order on art_in and
// each one turns into up to four times scale squared band-relative pixel writes on pix_out,
// the last of them flagged; a byte with no surviving write produces nothing. The pixel
// walker in the back end steps through every replica of each drawn pixel and over each
// transparent or padding pixel. It also stalls when a byte's first kept write comes up while
// the previous byte's final write is still being sent out as last, and while pix_out is held
// off; that walker sets the rate. A two-entry queue sits between the byte classifier and the
// walker, so new bytes are taken while earlier ones are still being drawn, and pix_out is
// driven from a register. Row and byte counters follow the sprite geometry and wrap after
// its last byte. The user must write registers through wr_en/wr_index/wr_data only while no
// byte is in flight; the block itself does not enforce it.
`include "scaled_sprite_blitter_2bpp_macros.svh"
module scaled_sprite_blitter_2bpp import ssb_pkg::*; #(
	parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
	parameter int BAND_HEIGHT  = DEF_BAND_HEIGHT,
	parameter int STAGE_TOP    = DEF_STAGE_TOP,
	parameter int MAX_ART_SIDE = DEF_MAX_ART_SIDE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [47:0] wr_data,
	ssb_in_if.sink      art_in,
	ssb_out_if.source   pix_out
);

	ssb_cfg_t          cfg_q;
	ssb_item_t         front_item, q_item;
	ssb_stat_t         stat;
	logic              q_full, q_empty, q_pop, push;
	logic [QCNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_y        <= '0;
			cfg_q.art_width     <= 6'd1;
			cfg_q.art_height    <= 6'd1;
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.scale         <= 2'd1;
			cfg_q.flip_bits     <= '0;
			cfg_q.palette_words <= '0;
		end else if (wr_en) begin
			case (ssb_reg_t'(wr_index))
				REG_BAND_Y:     cfg_q.band_y        <= wr_data[7:0];
				REG_ART_WIDTH:  cfg_q.art_width     <= wr_data[5:0];
				REG_ART_HEIGHT: cfg_q.art_height    <= wr_data[5:0];
				REG_CENTER_X:   cfg_q.center_x      <= wr_data[9:0];
				REG_CENTER_Y:   cfg_q.center_y      <= wr_data[9:0];
				REG_SCALE:      cfg_q.scale         <= wr_data[1:0];
				REG_FLIP_BITS:  cfg_q.flip_bits     <= wr_data[1:0];
				REG_PALETTE:    cfg_q.palette_words <= wr_data;
				default: ;
			endcase
		end
	end

	assign push         = art_in.valid && !q_full;
	assign art_in.ready = !q_full;

	ssb_front #(
		.MAX_ART_SIDE(MAX_ART_SIDE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.take     (push),
		.art_byte (art_in.art_byte),
		.item     (front_item)
	);

	ssb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (front_item),
		.pop      (q_pop),
		.item_out (q_item),
		.full     (q_full),
		.empty    (q_empty),
		.count    (q_count)
	);

	ssb_back #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.BAND_HEIGHT (BAND_HEIGHT),
		.STAGE_TOP   (STAGE_TOP)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.stat    (stat),
		.pix_out (pix_out)
	);

	// The queue never holds more than its depth.
	`SSB_ASSERT_IMP(a_queue_bound, 1'b1, q_count <= QDEPTH)
	// A pending write always belongs to a byte in progress or to a pending end-of-byte flush.
	`SSB_ASSERT_IMP(a_hold_owned, stat.hold, stat.busy || stat.flush)
	// An accepted byte is in the queue in the following cycle.
	`SSB_ASSERT_NEXT(a_request_queued, art_in.valid && art_in.ready, q_count != '0)

endmodule
`default_nettype wire

// ===== rtl/core/ssb_front.sv =====
`default_nettype none
module ssb_front import ssb_pkg::*; #(
	parameter int MAX_ART_SIDE = DEF_MAX_ART_SIDE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ssb_cfg_t   cfg,
	input  logic       take,
	input  logic [7:0] art_byte,
	output ssb_item_t  item
);

	localparam int ROW_W = (MAX_ART_SIDE > 1) ? $clog2(MAX_ART_SIDE) : 1;
	localparam int COL_W = (MAX_ART_SIDE > 4) ? $clog2((MAX_ART_SIDE + 3) / 4) : 1;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_n;
	logic [COL_W-1:0]  col_n;

	logic [SIDE_W-1:0] w, h, stride, rc, bc, y, sx0, x0, col1, row1;
	logic [SIDE_W-1:0] sxk [4];
	logic [8:0]        ws, hs, ys, xs;
	logic signed [CW-1:0] cx, cy, left, top;

	always_comb begin
		w = (cfg.art_width == '0) ? SIDE_W'(1) :
			(({1'b0, cfg.art_width} > SIDE_W'(MAX_ART_SIDE)) ? SIDE_W'(MAX_ART_SIDE) :
			{1'b0, cfg.art_width});
		h = (cfg.art_height == '0) ? SIDE_W'(1) :
			(({1'b0, cfg.art_height} > SIDE_W'(MAX_ART_SIDE)) ? SIDE_W'(MAX_ART_SIDE) :
			{1'b0, cfg.art_height});
		stride = (w + SIDE_W'(3)) >> 2;

		// A geometry change can leave the counters beyond the new sprite.
		rc = (SIDE_W'(row_q) >= h) ? '0 : SIDE_W'(row_q);
		bc = (SIDE_W'(col_q) >= stride) ? '0 : SIDE_W'(col_q);

		y   = cfg.flip_bits[1] ? (h - SIDE_W'(1) - rc) : rc;
		sx0 = bc << 2;
		x0  = cfg.flip_bits[0] ? (w - SIDE_W'(1) - sx0) : sx0;

		ws = 9'(w) * 9'(cfg.scale);
		hs = 9'(h) * 9'(cfg.scale);
		ys = 9'(y) * 9'(cfg.scale);
		xs = 9'(x0) * 9'(cfg.scale);

		cx   = {{(CW-10){cfg.center_x[9]}}, cfg.center_x};
		cy   = {{(CW-10){cfg.center_y[9]}}, cfg.center_y};
		left = cx - $signed(CW'(ws >> 1));
		top  = cy - $signed(CW'(hs >> 1));

		item.shades = art_byte;
		item.dy     = top + $signed(CW'(ys));
		item.pxb    = left + $signed(CW'(xs));
		for (int k = 0; k < 4; k++) begin
			sxk[k] = sx0 + SIDE_W'(k);
			item.mask[k] = (sxk[k] < w) && (art_byte[7-2*k -: 2] != SHADE_CLEAR) &&
				(cfg.scale != 2'd0);
		end

		col1 = bc + SIDE_W'(1);
		row1 = rc + SIDE_W'(1);
		if (col1 >= stride) begin
			col_n = '0;
			row_n = (row1 >= h) ? '0 : ROW_W'(row1);
		end else begin
			col_n = COL_W'(col1);
			row_n = ROW_W'(rc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			row_q <= row_n;
			col_q <= col_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ssb_queue.sv =====
`default_nettype none
module ssb_queue import ssb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ssb_item_t         item_in,
	input  logic              pop,
	output ssb_item_t         item_out,
	output logic              full,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	ssb_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign item_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ssb_back.sv =====
`default_nettype none
module ssb_back import ssb_pkg::*; #(
	parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
	parameter int BAND_HEIGHT  = DEF_BAND_HEIGHT,
	parameter int STAGE_TOP    = DEF_STAGE_TOP
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ssb_cfg_t  cfg,
	input  logic      q_empty,
	input  ssb_item_t q_item,
	output logic      q_pop,
	output ssb_stat_t stat,
	ssb_out_if.source pix_out
);

	function automatic logic in_hud(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		logic hit;
		hit = (x < HUD_A_X2 && y < HUD_A_Y2) ||
			(x >= HUD_B_X1 && x < HUD_B_X2 && y >= HUD_B_Y1 && y < HUD_B_Y2) ||
			(x >= HUD_C_X1 && x < HUD_C_X2 && y >= HUD_C_Y1 && y < HUD_C_Y2) ||
			(x >= HUD_D_X1 && x < HUD_D_X2 && y >= HUD_D_Y1 && y < HUD_D_Y2) ||
			(x >= HUD_E_X1 && x < HUD_E_X2 && y >= HUD_E_Y1 && y < HUD_E_Y2);
		return hit;
	endfunction

	logic                 cur_v_q, fl_q, hold_v_q, out_v_q;
	logic [1:0]           k_q, xx_q, yy_q;
	logic signed [CW-1:0] px_q, py_q, pxb_q, dy_q;
	logic [7:0]           shades_q;
	logic [3:0]           mask_q;
	logic [7:0]           hold_x_q, out_x_q;
	logic [3:0]           hold_row_q, out_row_q;
	logic [15:0]          hold_color_q, out_color_q;
	logic                 out_last_q;

	logic [1:0]           shade;
	logic [15:0]          color;
	logic signed [CW-1:0] by, rel, scl, step_pxb;
	logic                 in_view, kept, last_x, last_y, px_done, is_end;
	logic                 out_free, fl_done, adv, load, hold_to_out, flush_out;

	always_comb begin
		case (k_q)
			2'd0:    shade = shades_q[7:6];
			2'd1:    shade = shades_q[5:4];
			2'd2:    shade = shades_q[3:2];
			default: shade = shades_q[1:0];
		endcase
		case (shade)
			2'd0:    color = cfg.palette_words[15:0];
			2'd1:    color = cfg.palette_words[31:16];
			default: color = cfg.palette_words[47:32];
		endcase

		by  = $signed({{(CW-8){1'b0}}, cfg.band_y});
		rel = py_q - by;
		scl = $signed(CW'(cfg.scale));
		step_pxb = cfg.flip_bits[0] ? (pxb_q - scl) : (pxb_q + scl);

		in_view = (py_q >= by) && (py_q < by + BAND_HEIGHT) &&
			(py_q >= STAGE_TOP) && (py_q < STAGE_BOTTOM) && (px_q >= 0) &&
			(px_q < ((py_q < LOW_ROW) ? SCREEN_WIDTH : LOW_RIGHT)) && !in_hud(px_q, py_q);
		kept = cur_v_q && mask_q[k_q] && in_view;

		last_x  = (xx_q == cfg.scale - 2'd1);
		last_y  = (yy_q == cfg.scale - 2'd1);
		px_done = !mask_q[k_q] || (last_x && last_y);
		is_end  = (k_q == 2'd3) && px_done;

		out_free = !out_v_q || pix_out.ready;
		fl_done  = fl_q && (!hold_v_q || out_free);

		// The held write can only be released as not-last once a later write of the
		// same byte shows up; the end of the byte releases it as last.
		adv = cur_v_q && !(kept && (fl_q || (hold_v_q && !out_free))) &&
			!(is_end && fl_q && !fl_done);
		load = !q_empty && (!cur_v_q || (adv && is_end));
		hold_to_out = adv && kept && hold_v_q;
		flush_out   = fl_q && hold_v_q && out_free;
	end

	assign q_pop = load;
	assign stat  = '{busy: cur_v_q, flush: fl_q, hold: hold_v_q};

	assign pix_out.valid     = out_v_q;
	assign pix_out.pixel_x   = out_x_q;
	assign pix_out.pixel_row = out_row_q;
	assign pix_out.color     = out_color_q;
	assign pix_out.last      = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q  <= 1'b0;
			fl_q     <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			k_q      <= '0;
			xx_q     <= '0;
			yy_q     <= '0;
		end else begin
			if (load) begin
				cur_v_q <= 1'b1;
			end else if (adv && is_end) begin
				cur_v_q <= 1'b0;
			end
			fl_q <= (fl_q && !fl_done) || (adv && is_end);
			if (adv && kept) begin
				hold_v_q <= 1'b1;
			end else if (flush_out) begin
				hold_v_q <= 1'b0;
			end
			if (hold_to_out || flush_out) begin
				out_v_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_v_q <= 1'b0;
			end
			if (load) begin
				k_q  <= '0;
				xx_q <= '0;
				yy_q <= '0;
			end else if (adv) begin
				if (px_done) begin
					k_q  <= k_q + 2'd1;
					xx_q <= '0;
					yy_q <= '0;
				end else if (last_x) begin
					xx_q <= '0;
					yy_q <= yy_q + 2'd1;
				end else begin
					xx_q <= xx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q     <= q_item.pxb;
			py_q     <= q_item.dy;
			pxb_q    <= q_item.pxb;
			dy_q     <= q_item.dy;
			shades_q <= q_item.shades;
			mask_q   <= q_item.mask;
		end else if (adv) begin
			if (px_done) begin
				pxb_q <= step_pxb;
				px_q  <= step_pxb;
				py_q  <= dy_q;
			end else if (last_x) begin
				px_q <= pxb_q;
				py_q <= py_q + CW'(1);
			end else begin
				px_q <= px_q + CW'(1);
			end
		end
		if (adv && kept) begin
			hold_x_q     <= px_q[7:0];
			hold_row_q   <= rel[3:0];
			hold_color_q <= color;
		end
		if (hold_to_out || flush_out) begin
			out_x_q     <= hold_x_q;
			out_row_q   <= hold_row_q;
			out_color_q <= hold_color_q;
			out_last_q  <= flush_out;
		end
	end

endmodule
`default_nettype wire

// ===== tb/scaled_sprite_blitter_2bpp_tb.sv =====
`default_nettype none
module scaled_sprite_blitter_2bpp_tb;
	import ssb_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam int WAIT_LIMIT   = 20000;
	localparam int LONG_HOLD    = 300;
	localparam int RAND_ITEMS   = 108;

	typedef struct packed {
		logic [7:0]  x;
		logic [3:0]  row;
		logic [15:0] color;
		logic        last;
	} pix_wr_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        wr_en     = 1'b0;
	logic [2:0]  wr_index  = 3'd0;
	logic [47:0] wr_data   = '0;
	logic        art_valid = 1'b0;
	logic [7:0]  art_data  = 8'h00;
	logic        pix_ready = 1'b0;

	ssb_in_if  art_in ();
	ssb_out_if pix_out ();

	assign art_in.valid    = art_valid;
	assign art_in.art_byte = art_data;
	assign pix_out.ready   = pix_ready;

	scaled_sprite_blitter_2bpp dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.art_in   (art_in),
		.pix_out  (pix_out)
	);

	// Shadow of the register file and of the sprite walk position.
	ssb_cfg_t   sprite_cfg;
	int         row_cnt;
	int         byte_idx;
	logic [7:0] art_queue[$];
	pix_wr_t    pending_writes[$];
	int         mismatches    = 0;
	int         send_idle_pct = 0;
	int         rcv_idle_pct  = 0;
	int         stall_reqs    = 0;
	int         stall_seen    = 0;
	int         hold_left     = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic bit pixel_visible(int x, int y);
		int band;
		int right;
		band = int'(sprite_cfg.band_y);
		if (y < band || y >= band + DEF_BAND_HEIGHT) return 1'b0;
		if (y < DEF_STAGE_TOP || y >= STAGE_BOTTOM) return 1'b0;
		right = (y < LOW_ROW) ? DEF_SCREEN_WIDTH : LOW_RIGHT;
		if (x < 0 || x >= right) return 1'b0;
		if (x < HUD_A_X2 && y < HUD_A_Y2) return 1'b0;
		if (x >= HUD_B_X1 && x < HUD_B_X2 && y >= HUD_B_Y1 && y < HUD_B_Y2) return 1'b0;
		if (x >= HUD_C_X1 && x < HUD_C_X2 && y >= HUD_C_Y1 && y < HUD_C_Y2) return 1'b0;
		if (x >= HUD_D_X1 && x < HUD_D_X2 && y >= HUD_D_Y1 && y < HUD_D_Y2) return 1'b0;
		if (x >= HUD_E_X1 && x < HUD_E_X2 && y >= HUD_E_Y1 && y < HUD_E_Y2) return 1'b0;
		return 1'b1;
	endfunction

	function automatic int clamp_side(logic [5:0] v);
		if (v == 0) return 1;
		if (v > DEF_MAX_ART_SIDE) return DEF_MAX_ART_SIDE;
		return int'(v);
	endfunction

	// Works out every pixel write one sprite byte causes and advances the walk.
	function automatic void predict_writes(logic [7:0] art);
		int w, h, s, stride, left, top, dy, sx, col, first, k, yy, xx;
		logic [1:0] shade;
		pix_wr_t wr;
		w = clamp_side(sprite_cfg.art_width);
		h = clamp_side(sprite_cfg.art_height);
		s = int'(sprite_cfg.scale);
		stride = (w + 3) / 4;
		if (row_cnt >= h) row_cnt = 0;
		if (byte_idx >= stride) byte_idx = 0;
		first = pending_writes.size();
		if (s >= 1) begin
			left = int'($signed(sprite_cfg.center_x)) - (w * s) / 2;
			top  = int'($signed(sprite_cfg.center_y)) - (h * s) / 2;
			dy = top + (sprite_cfg.flip_bits[1] ? h - 1 - row_cnt : row_cnt) * s;
			for (k = 0; k < 4; k++) begin
				sx = byte_idx * 4 + k;
				shade = art[7 - 2 * k -: 2];
				if (sx < w && shade != SHADE_CLEAR) begin
					col = sprite_cfg.flip_bits[0] ? w - 1 - sx : sx;
					wr.color = sprite_cfg.palette_words[16 * shade +: 16];
					wr.last = 1'b0;
					for (yy = 0; yy < s; yy++) begin
						for (xx = 0; xx < s; xx++) begin
							if (pixel_visible(left + col * s + xx, dy + yy)) begin
								wr.x = 8'(left + col * s + xx);
								wr.row = 4'(dy + yy - int'(sprite_cfg.band_y));
								pending_writes.push_back(wr);
							end
						end
					end
				end
			end
		end
		if (pending_writes.size() > first) begin
			pending_writes[pending_writes.size() - 1].last = 1'b1;
		end
		byte_idx++;
		if (byte_idx >= stride) begin
			byte_idx = 0;
			row_cnt++;
			if (row_cnt >= h) row_cnt = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			art_valid <= 1'b0;
			art_data <= 8'h00;
		end else begin
			if (art_valid && art_in.ready) begin
				predict_writes(art_data);
			end
			// A new request is offered only once the current one has been taken.
			if (!art_valid || art_in.ready) begin
				if (art_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					art_valid <= 1'b1;
					art_data <= art_queue.pop_front();
				end else begin
					art_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : pixel_monitor
		pix_wr_t want;
		if (!arst_n) begin
			pix_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (pix_out.valid && pix_ready) begin
				if (pending_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected write x=%0d row=%0d color=%h last=%b",
						pix_out.pixel_x, pix_out.pixel_row, pix_out.color, pix_out.last));
				end else begin
					want = pending_writes.pop_front();
					if (pix_out.pixel_x !== want.x)
						report_mismatch($sformatf("pixel_x got %0d want %0d",
							pix_out.pixel_x, want.x));
					if (pix_out.pixel_row !== want.row)
						report_mismatch($sformatf("pixel_row got %0d want %0d",
							pix_out.pixel_row, want.row));
					if (pix_out.color !== want.color)
						report_mismatch($sformatf("color got %h want %h",
							pix_out.color, want.color));
					if (pix_out.last !== want.last)
						report_mismatch($sformatf("last got %b want %b",
							pix_out.last, want.last));
				end
			end
			if (stall_reqs != stall_seen) begin
				stall_seen = stall_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_ready <= 1'b0;
			end else begin
				pix_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	task automatic write_reg(ssb_reg_t idx, logic [47:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
			REG_BAND_Y:     sprite_cfg.band_y = value[7:0];
			REG_ART_WIDTH:  sprite_cfg.art_width = value[5:0];
			REG_ART_HEIGHT: sprite_cfg.art_height = value[5:0];
			REG_CENTER_X:   sprite_cfg.center_x = value[9:0];
			REG_CENTER_Y:   sprite_cfg.center_y = value[9:0];
			REG_SCALE:      sprite_cfg.scale = value[1:0];
			REG_FLIP_BITS:  sprite_cfg.flip_bits = value[1:0];
			REG_PALETTE:    sprite_cfg.palette_words = value;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic load_sprite(logic [7:0] band, logic [5:0] w, logic [5:0] h, logic [9:0] cx,
		logic [9:0] cy, logic [1:0] s, logic [1:0] flip, logic [47:0] pal);
		write_reg(REG_BAND_Y, 48'(band));
		write_reg(REG_ART_WIDTH, 48'(w));
		write_reg(REG_ART_HEIGHT, 48'(h));
		write_reg(REG_CENTER_X, 48'(cx));
		write_reg(REG_CENTER_Y, 48'(cy));
		write_reg(REG_SCALE, 48'(s));
		write_reg(REG_FLIP_BITS, 48'(flip));
		write_reg(REG_PALETTE, pal);
	endtask

	// Bytes that draw nothing leave no trace, so a fixed tail follows the last write.
	task automatic drain_blitter();
		int waited;
		waited = 0;
		while ((art_queue.size() != 0 || art_valid || pending_writes.size() != 0)
			&& waited < WAIT_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int rand_items, phase, n, w, h, stride, r, c, band, cx, cy, sc, i;
		logic [63:0] pal64;
		sprite_cfg = '{band_y: 8'd0, art_width: 6'd1, art_height: 6'd1, center_x: 10'd0,
			center_y: 10'd0, scale: 2'd1, flip_bits: 2'd0, palette_words: 48'd0};
		row_cnt = 0;
		byte_idx = 0;
		send_idle_pct = 6;
		rcv_idle_pct = 62;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scale 3 fully inside the band; the first byte is all drawn, the padding pixels of
		// the second byte of the first row carry shade 0 and must stay hidden; the fifth byte wraps.
		load_sprite(8'd100, 6'd5, 6'd2, 10'd170, 10'd108, 2'd3, 2'd0, 48'h1234_5678_9ABC);
		art_queue.push_back(8'h00);
		art_queue.push_back(8'h00);
		art_queue.push_back(8'hE4);
		art_queue.push_back(8'hBF);
		art_queue.push_back(8'h1B);
		drain_blitter();
		// Both mirrors at once, white palette.
		load_sprite(8'd52, 6'd7, 6'd3, 10'd200, 10'd60, 2'd2, 2'd3, 48'hFFFF_FFFF_FFFF);
		art_queue.push_back(8'h12);
		art_queue.push_back(8'h34);
		art_queue.push_back(8'h56);
		art_queue.push_back(8'h9A);
		drain_blitter();
		// Straddles row 160, where the right edge pulls in.
		load_sprite(8'd152, 6'd8, 6'd4, 10'd104, 10'd162, 2'd3, 2'd1, 48'hA5A5_0F0F_C3C3);
		art_queue.push_back(8'h00);
		art_queue.push_back(8'h66);
		art_queue.push_back(8'h00);
		art_queue.push_back(8'h99);
		drain_blitter();
		// Scale zero with zero sizes and extreme center: nothing drawn, walk still moves.
		load_sprite(8'd255, 6'd0, 6'd0, 10'h200, 10'h1FF, 2'd0, 2'd1, 48'd0);
		art_queue.push_back(8'h00);
		art_queue.push_back(8'hFF);
		drain_blitter();
		// Oversized sides clamp to the maximum; the sprite lands off screen.
		load_sprite(8'd0, 6'd63, 6'd63, 10'h1FF, 10'h200, 2'd3, 2'd2, 48'h0001_0002_0004);
		art_queue.push_back(8'h00);
		art_queue.push_back(8'h55);
		drain_blitter();
		// Left screen edge and stage bottom.
		load_sprite(8'd224, 6'd4, 6'd4, 10'd4, 10'd232, 2'd3, 2'd0, 48'h8000_4000_2000);
		art_queue.push_back(8'h00);
		art_queue.push_back(8'h55);
		art_queue.push_back(8'hAA);
		drain_blitter();
		// Stage top clips the upper replica rows.
		load_sprite(8'd20, 6'd4, 6'd4, 10'd200, 10'd24, 2'd2, 2'd0, 48'h7777_3333_1111);
		art_queue.push_back(8'h00);
		art_queue.push_back(8'h1B);
		drain_blitter();

		rand_items = 0;
		phase = 0;
		while (rand_items < RAND_ITEMS) begin
			if (rand_items < RAND_ITEMS / 3) begin
				send_idle_pct = 6;
				rcv_idle_pct = 62;
			end else if (rand_items < 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 62;
				rcv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			pal64 = {$urandom(), $urandom()};
			if (phase % 5 == 4) begin
				// Stray configuration and a broken run of bytes.
				load_sprite(8'($urandom_range(255)), 6'($urandom_range(63)),
					6'($urandom_range(63)), 10'($urandom()), 10'($urandom()),
					2'($urandom_range(3)), 2'($urandom_range(3)), pal64[47:0]);
				n = $urandom_range(1, 6);
			end else begin
				w = ($urandom_range(9) == 0) ? 32 : $urandom_range(1, 12);
				h = (w == 32) ? $urandom_range(1, 2) : $urandom_range(1, 5);
				band = $urandom_range(16, 220);
				cy = band + $urandom_range(0, 20) - 4;
				cx = (band >= 150 && $urandom_range(1)) ? $urandom_range(0, 110)
					: $urandom_range(100, 260);
				sc = $urandom_range(1, 3);
				if (phase == 3) begin
					// A sprite clear of the HUD, so the long receiver stall backs up
					// into the input.
					w = 8;
					h = 4;
					band = 120;
					cy = 124;
					cx = 180;
					sc = 3;
				end
				stride = (w + 3) / 4;
				load_sprite(8'(band), 6'(w), 6'(h), 10'(cx), 10'(cy),
					2'(sc), 2'($urandom_range(3)), pal64[47:0]);
				// Finish the sprite the walk is in, then whole sprites after it.
				r = (row_cnt >= h) ? 0 : row_cnt;
				c = (byte_idx >= stride) ? 0 : byte_idx;
				n = (h - r) * stride - c + $urandom_range(0, 1) * stride * h;
				while (phase == 3 && n < 8) n += stride * h;
			end
			if (phase == 3) stall_reqs++;
			for (i = 0; i < n; i++) begin
				// The sender waits for every write of the first half before going on.
				if (phase == 6 && i == n / 2) drain_blitter();
				art_queue.push_back(8'($urandom()));
			end
			rand_items += n;
			phase++;
			drain_blitter();
		end

		if (pending_writes.size() != 0 || art_queue.size() != 0 || art_valid) begin
			report_mismatch($sformatf("%0d writes never arrived, %0d bytes never taken",
				pending_writes.size(), art_queue.size()));
		end
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
